[hw/rtl/ldm_pkg.sv]
`timescale 1ns / 1ps
package ldm_pkg;

  localparam int DATA_W    = 30;
  localparam int NODES_DEF = 64;
  localparam int FIELD_W   = 7;

  localparam logic [DATA_W-1:0] MOD_RESET = 30'd1000000007;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_DET = 2'd1,
    ACT_CLR = 2'd2,
    ACT_NOP = 2'd3
  } action_t;

  // request to the serial modular multiplier
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] a;   // must be below m
    logic [DATA_W-1:0] b;   // any value
    logic [DATA_W-1:0] m;
  } mm_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] res;
  } mm_rsp_t;

endpackage

[hw/rtl/ldm_if.sv]
`timescale 1ns / 1ps
interface ldm_in_if;
  import ldm_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [FIELD_W-1:0] node_a;
  logic [FIELD_W-1:0] node_b;
  logic [FIELD_W-1:0] minor_size;
  modport source (output valid, action, node_a, node_b, minor_size, input ready);
  modport sink   (input valid, action, node_a, node_b, minor_size, output ready);
endinterface

interface ldm_out_if;
  import ldm_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] det_value;
  modport source (output valid, det_value, input ready);
  modport sink   (input valid, det_value, output ready);
endinterface

interface ldm_cfg_if;
  import ldm_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] modulus;
  modport source (output valid, modulus, input ready);
  modport sink   (input valid, modulus, output ready);
endinterface

[hw/rtl/ldm_mem.sv]
`timescale 1ns / 1ps
module ldm_mem import ldm_pkg::*; #(
  parameter int DEPTH  = NODES_DEF * NODES_DEF,
  parameter int ADDR_W = $clog2(NODES_DEF * NODES_DEF)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/ldm_mulmod.sv]
`timescale 1ns / 1ps
module ldm_mulmod import ldm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  mm_req_t req,
  output mm_rsp_t rsp
);

  localparam int CNT_W = $clog2(DATA_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DATA_W - 1);

  logic [DATA_W-1:0] acc_r, a_r, b_r, m_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r;
  logic [DATA_W+1:0] sum, red1, red2, mx;

  // acc = 2*acc + bit*a, below 3m, so at most two subtractions
  always_comb begin
    mx   = {2'b00, m_r};
    sum  = {1'b0, acc_r, 1'b0} + (b_r[DATA_W-1] ? {2'b00, a_r} : '0);
    red1 = (sum >= mx) ? sum - mx : sum;
    red2 = (red1 >= mx) ? red1 - mx : red1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == LAST) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r <= '0;
      a_r   <= req.a;
      b_r   <= req.b;
      m_r   <= req.m;
      cnt_r <= '0;
    end else if (busy_r) begin
      acc_r <= red2[DATA_W-1:0];
      b_r   <= {b_r[DATA_W-2:0], 1'b0};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.res  = acc_r;

endmodule

[hw/rtl/laplacian_determinant_mod_prime.sv]
`timescale 1ns / 1ps
// Graph Laplacian store with a determinant engine, all arithmetic modulo a
// programmable prime. The NODES x NODES matrix lives in one single-port-read,
// single-port-write synchronous RAM and every edge add and determinant is a
// sequence of read, modify and write-back steps; one item is handled at a
// time, and in_ch.ready is high only while the sequencer idles. After reset,
// and after a clear beat, a clearing pass writes zero to all NODES*NODES
// entries, one per cycle. An add-edge beat takes four entry updates; an
// entry that is not below the current modulus (left from an older modulus)
// is first reduced by the multiplier. Products modulo m come from a
// bit-serial multiplier that handles one product at a time, and that unit
// sets the determinant time: the minor is reduced, then eliminated, with up
// to 60 products to invert each pivot, and the diagonal entries are then
// multiplied for the final product. A determinant of order 0 answers 1 at
// once. Elimination leaves the minor reduced in the store. The modulus is
// sampled when an item is accepted; write it only while the block is idle.
// A modulus below 2 acts as 2.
module laplacian_determinant_mod_prime import ldm_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  ldm_in_if.sink    in_ch,
  ldm_out_if.source out_ch,
  ldm_cfg_if.sink   cfg_ch
);

  localparam int DEPTH  = NODES * NODES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(NODES + 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] NODES_A   = ADDR_W'(NODES);

  typedef enum logic [29:0] {
    S_CLEAR   = 30'd1 << 0,
    S_IDLE    = 30'd1 << 1,
    S_FX_RD   = 30'd1 << 2,
    S_FX_GO   = 30'd1 << 3,
    S_FX_MUL  = 30'd1 << 4,
    S_FX_WR   = 30'd1 << 5,
    S_PV_RD   = 30'd1 << 6,
    S_PV_CHK  = 30'd1 << 7,
    S_SR_RD   = 30'd1 << 8,
    S_SR_CHK  = 30'd1 << 9,
    S_SW_RDI  = 30'd1 << 10,
    S_SW_RDJ  = 30'd1 << 11,
    S_SW_WI   = 30'd1 << 12,
    S_SW_WJ   = 30'd1 << 13,
    S_PIVOT   = 30'd1 << 14,
    S_PW_STEP = 30'd1 << 15,
    S_PW_MA   = 30'd1 << 16,
    S_PW_MB   = 30'd1 << 17,
    S_EL_RD   = 30'd1 << 18,
    S_EL_GO   = 30'd1 << 19,
    S_EL_M    = 30'd1 << 20,
    S_EK_RD   = 30'd1 << 21,
    S_EK_GO   = 30'd1 << 22,
    S_EK_M    = 30'd1 << 23,
    S_EK_WR   = 30'd1 << 24,
    S_PR_INIT = 30'd1 << 25,
    S_PR_RD   = 30'd1 << 26,
    S_PR_GO   = 30'd1 << 27,
    S_PR_M    = 30'd1 << 28,
    S_EMIT    = 30'd1 << 29
  } state_t;

  state_t state_r, state_nxt;

  // control registers
  logic [ADDR_W-1:0] clr_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] mod_cfg_r;

  // work registers, set before use
  logic [DATA_W-1:0] m_r, tmp_r, piv_r, inv_r, base_r, e_r, w_r, sub_r, sgn_r, prod_r;
  logic [DATA_W-1:0] det_r;
  logic [CNT_W-1:0]  i_r, j_r, k_r, n_r, na_r, nb_r;
  logic [1:0]        step_r;
  logic              copy_r;

  // memory and multiplier ports
  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [DATA_W-1:0] rd_data, wr_data;
  mm_req_t           mm_req;
  mm_rsp_t           mm_rsp;

  logic [CNT_W-1:0]  fr, fc;
  logic [DATA_W-1:0] fx_val, ek_val;
  logic [DATA_W:0]   ek_wide;
  logic              in_acc, add_ok;
  logic [DATA_W-1:0] m_eff;

  function automatic logic [ADDR_W-1:0] ent_addr(logic [CNT_W-1:0] r, logic [CNT_W-1:0] c);
    ent_addr = ADDR_W'(r) * NODES_A + ADDR_W'(c);
  endfunction

  ldm_mem #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  ldm_mulmod u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  assign in_ch.ready      = (state_r == S_IDLE);
  assign in_acc           = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.det_value = det_r;

  assign m_eff  = (mod_cfg_r < DATA_W'(2)) ? DATA_W'(2) : mod_cfg_r;
  assign add_ok = (in_ch.node_a != '0) && (32'(in_ch.node_a) <= NODES) &&
                  (in_ch.node_b != '0) && (32'(in_ch.node_b) <= NODES);

  // entry under update: edge steps touch aa, bb, ab, ba; the copy pass walks the minor
  always_comb begin
    if (copy_r) begin
      fr = i_r;
      fc = k_r;
    end else begin
      unique case (step_r)
        2'd0:    begin fr = na_r; fc = na_r; end
        2'd1:    begin fr = nb_r; fc = nb_r; end
        2'd2:    begin fr = na_r; fc = nb_r; end
        default: begin fr = nb_r; fc = na_r; end
      endcase
    end
  end

  // new value of the updated entry
  always_comb begin
    if (copy_r) begin
      fx_val = tmp_r;
    end else if (!step_r[1]) begin
      fx_val = (tmp_r + 1'b1 == m_r) ? '0 : tmp_r + 1'b1;
    end else begin
      fx_val = (tmp_r == '0) ? m_r - 1'b1 : tmp_r - 1'b1;
    end
  end

  assign ek_wide = {1'b0, rd_data} + {1'b0, m_r} - {1'b0, sub_r};
  assign ek_val  = (rd_data >= sub_r) ? rd_data - sub_r : ek_wide[DATA_W-1:0];

  // memory and multiplier drive
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = ent_addr(i_r, i_r);
    wr_en     = 1'b0;
    wr_addr   = ent_addr(fr, fc);
    wr_data   = fx_val;
    mm_req    = '0;
    mm_req.m  = m_r;
    mm_req.a  = base_r;
    mm_req.b  = base_r;
    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
      end
      S_FX_RD: begin
        rd_en   = 1'b1;
        rd_addr = ent_addr(fr, fc);
      end
      S_FX_GO: begin
        mm_req.start = (rd_data >= m_r);
        mm_req.a     = DATA_W'(1);
        mm_req.b     = rd_data;
      end
      S_FX_WR:  wr_en = 1'b1;
      S_PV_RD:  rd_en = 1'b1;
      S_SR_RD: begin
        rd_en   = 1'b1;
        rd_addr = ent_addr(j_r, i_r);
      end
      S_SW_RDI: begin
        rd_en   = 1'b1;
        rd_addr = ent_addr(i_r, k_r);
      end
      S_SW_RDJ: begin
        rd_en   = 1'b1;
        rd_addr = ent_addr(j_r, k_r);
      end
      S_SW_WI: begin
        wr_en   = 1'b1;
        wr_addr = ent_addr(i_r, k_r);
        wr_data = rd_data;
      end
      S_SW_WJ: begin
        wr_en   = 1'b1;
        wr_addr = ent_addr(j_r, k_r);
        wr_data = tmp_r;
      end
      S_PW_STEP: begin
        mm_req.start = (e_r != '0);
        mm_req.a     = e_r[0] ? inv_r : base_r;
      end
      S_PW_MA: mm_req.start = mm_rsp.done;
      S_EL_RD: begin
        rd_en   = 1'b1;
        rd_addr = ent_addr(j_r, i_r);
      end
      S_EL_GO: begin
        mm_req.start = 1'b1;
        mm_req.a     = inv_r;
        mm_req.b     = rd_data;
      end
      S_EK_RD: begin
        rd_en   = 1'b1;
        rd_addr = ent_addr(i_r, k_r);
      end
      S_EK_GO: begin
        mm_req.start = 1'b1;
        mm_req.a     = w_r;
        mm_req.b     = rd_data;
      end
      S_EK_M: begin
        rd_en   = mm_rsp.done;
        rd_addr = ent_addr(j_r, k_r);
      end
      S_EK_WR: begin
        wr_en   = 1'b1;
        wr_addr = ent_addr(j_r, k_r);
        wr_data = ek_val;
      end
      S_PR_RD: rd_en = 1'b1;
      S_PR_GO: begin
        mm_req.start = 1'b1;
        mm_req.a     = prod_r;
        mm_req.b     = rd_data;
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:   if (clr_r == LAST_ADDR) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          priority if (in_ch.action == ACT_ADD && add_ok) state_nxt = S_FX_RD;
          else if (in_ch.action == ACT_DET) begin
            state_nxt = (in_ch.minor_size == '0) ? S_EMIT : S_FX_RD;
          end else if (in_ch.action == ACT_CLR) state_nxt = S_CLEAR;
          else state_nxt = S_IDLE;
        end
      end
      S_FX_RD:   state_nxt = S_FX_GO;
      S_FX_GO:   state_nxt = (rd_data >= m_r) ? S_FX_MUL : S_FX_WR;
      S_FX_MUL:  if (mm_rsp.done) state_nxt = S_FX_WR;
      S_FX_WR: begin
        if (!copy_r) begin
          state_nxt = (step_r == 2'd3) ? S_IDLE : S_FX_RD;
        end else if (k_r + 1'b1 == n_r && i_r + 1'b1 == n_r) begin
          state_nxt = S_PV_RD;
        end else begin
          state_nxt = S_FX_RD;
        end
      end
      S_PV_RD:   state_nxt = S_PV_CHK;
      S_PV_CHK: begin
        priority if (rd_data != '0) state_nxt = S_PIVOT;
        else if (i_r + 1'b1 == n_r) state_nxt = S_PR_INIT;
        else state_nxt = S_SR_RD;
      end
      S_SR_RD:   state_nxt = S_SR_CHK;
      S_SR_CHK: begin
        priority if (rd_data != '0) state_nxt = S_SW_RDI;
        else if (j_r + 1'b1 == n_r) state_nxt = S_PR_INIT;
        else state_nxt = S_SR_RD;
      end
      S_SW_RDI:  state_nxt = S_SW_RDJ;
      S_SW_RDJ:  state_nxt = S_SW_WI;
      S_SW_WI:   state_nxt = S_SW_WJ;
      S_SW_WJ:   state_nxt = (k_r + 1'b1 == n_r) ? S_PIVOT : S_SW_RDI;
      S_PIVOT:   state_nxt = (i_r + 1'b1 == n_r) ? S_PR_INIT : S_PW_STEP;
      S_PW_STEP: begin
        priority if (e_r == '0) state_nxt = S_EL_RD;
        else if (e_r[0]) state_nxt = S_PW_MA;
        else state_nxt = S_PW_MB;
      end
      S_PW_MA:   if (mm_rsp.done) state_nxt = S_PW_MB;
      S_PW_MB:   if (mm_rsp.done) state_nxt = S_PW_STEP;
      S_EL_RD:   state_nxt = S_EL_GO;
      S_EL_GO:   state_nxt = S_EL_M;
      S_EL_M:    if (mm_rsp.done) state_nxt = S_EK_RD;
      S_EK_RD:   state_nxt = S_EK_GO;
      S_EK_GO:   state_nxt = S_EK_M;
      S_EK_M:    if (mm_rsp.done) state_nxt = S_EK_WR;
      S_EK_WR: begin
        priority if (k_r + 1'b1 != n_r) state_nxt = S_EK_RD;
        else if (j_r + 1'b1 != n_r) state_nxt = S_EL_RD;
        else state_nxt = S_PV_RD;
      end
      S_PR_INIT: state_nxt = S_PR_RD;
      S_PR_RD:   state_nxt = S_PR_GO;
      S_PR_GO:   state_nxt = S_PR_M;
      S_PR_M:    if (mm_rsp.done) state_nxt = (i_r + 1'b1 == n_r) ? S_EMIT : S_PR_RD;
      S_EMIT:    if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      mod_cfg_r   <= MOD_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        mod_cfg_r <= cfg_ch.modulus;
      end
      if (state_r == S_CLEAR) begin
        clr_r <= (clr_r == LAST_ADDR) ? '0 : clr_r + 1'b1;
      end
      // hold the result until taken; load the next one when the slot frees
      if (state_r == S_EMIT && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          m_r    <= m_eff;
          na_r   <= CNT_W'(32'(in_ch.node_a) - 32'd1);
          nb_r   <= CNT_W'(32'(in_ch.node_b) - 32'd1);
          n_r    <= (32'(in_ch.minor_size) > NODES) ? CNT_W'(NODES) : CNT_W'(in_ch.minor_size);
          copy_r <= (in_ch.action == ACT_DET);
          step_r <= '0;
          i_r    <= '0;
          k_r    <= '0;
          sgn_r  <= DATA_W'(1);
          prod_r <= DATA_W'(1);
        end
      end
      S_FX_GO:  tmp_r <= rd_data;
      S_FX_MUL: if (mm_rsp.done) tmp_r <= mm_rsp.res;
      S_FX_WR: begin
        step_r <= step_r + 1'b1;
        if (copy_r) begin
          if (k_r + 1'b1 == n_r) begin
            k_r <= '0;
            i_r <= (i_r + 1'b1 == n_r) ? '0 : i_r + 1'b1;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
      end
      S_PV_CHK: begin
        piv_r <= rd_data;
        j_r   <= i_r + 1'b1;
      end
      S_SR_CHK: begin
        if (rd_data != '0) begin
          piv_r <= rd_data;
          sgn_r <= (sgn_r == '0) ? '0 : m_r - sgn_r;
          k_r   <= i_r;
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
      S_SW_RDJ: tmp_r <= rd_data;
      S_SW_WJ:  k_r <= k_r + 1'b1;
      S_PIVOT: begin
        e_r    <= m_r - DATA_W'(2);
        base_r <= piv_r;
        inv_r  <= DATA_W'(1);
        j_r    <= i_r + 1'b1;
      end
      S_PW_MA: if (mm_rsp.done) inv_r <= mm_rsp.res;
      S_PW_MB: begin
        if (mm_rsp.done) begin
          base_r <= mm_rsp.res;
          e_r    <= e_r >> 1;
        end
      end
      S_EL_M: begin
        if (mm_rsp.done) begin
          w_r <= mm_rsp.res;
          k_r <= i_r;
        end
      end
      S_EK_M: if (mm_rsp.done) sub_r <= mm_rsp.res;
      S_EK_WR: begin
        if (k_r + 1'b1 != n_r) begin
          k_r <= k_r + 1'b1;
        end else if (j_r + 1'b1 != n_r) begin
          j_r <= j_r + 1'b1;
        end else begin
          i_r <= i_r + 1'b1;
        end
      end
      S_PR_INIT: begin
        i_r    <= '0;
        prod_r <= sgn_r;
      end
      S_PR_M: begin
        if (mm_rsp.done) begin
          prod_r <= mm_rsp.res;
          i_r    <= i_r + 1'b1;
        end
      end
      S_EMIT: if (!out_valid_r || out_ch.ready) det_r <= prod_r;
      default: ;
    endcase
  end

  // multiplier is only started when it is free
  assert property (@(posedge clk) disable iff (!rst_n) mm_req.start |-> !mm_rsp.busy)
    else $error("multiplier started while busy");

  // no store traffic while waiting for a beat
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == S_IDLE) |-> (!wr_en && !rd_en))
    else $error("memory access while idle");

  // sign stays a canonical residue through elimination
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == S_PR_INIT) |-> (sgn_r < m_r))
    else $error("sign not reduced");

  // a result is loaded only out of the emit step
  assert property (@(posedge clk) disable iff (!rst_n)
                   $rose(out_valid_r) |-> ($past(state_r) == S_EMIT))
    else $error("result raised outside emit");

endmodule
